/* src/hld_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hld_pkg: shared definitions for the hex line display loader
// Character codes, parameter defaults, the emit sequencer states and the
// hex digit decoder.
// ----------------------------------------------------------------------------
package hld_pkg;

	// Parameter defaults.
	localparam int DISPLAY_BYTES_DEF = 32;
	localparam int LINE_LIMIT_DEF    = 256;

	// Character codes.
	localparam logic [7:0] CHAR_AT = 8'h40;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	// Emit sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_OUT
	} state_t;

	// Result of decoding one character as a hex digit.
	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_t;

	// Decodes 0-9, a-f and A-F; anything else is not a digit.
	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		r.ok    = 1'b1;
		r.value = 4'h0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.value = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			// Letters a-f and A-F share their low three bits: 1..6 maps to 10..15.
			r.value = 4'(c[2:0] + 3'd1) + 4'd8;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* src/hex_line_display_loader.sv */
`timescale 1ns / 1ps
`default_nettype none
// A newline that ends an '@' line starts the image emit; its first byte is
// read in the read state and shown in the output state.
// Throughput: one character per cycle outside an emit; each image byte of the
// emit takes a memory read, then the output register, stalls extending it.
// Reset: asynchronous, active low; clears the line state and the byte count, so
// the display memory needs no clearing pass.
// ----------------------------------------------------------------------------
// hex_line_display_loader: collects characters into lines and loads a display
// Parses '@' lines of hex digit pairs into a display memory and emits the
// whole image at the newline, unwritten bytes reading as zero.
// ----------------------------------------------------------------------------
module hex_line_display_loader #(
	parameter int DISPLAY_BYTES = hld_pkg::DISPLAY_BYTES_DEF,
	parameter int LINE_LIMIT    = hld_pkg::LINE_LIMIT_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      display_byte,
	output logic [5:0]      byte_index,
	output logic            last
);

	localparam int AW = (DISPLAY_BYTES > 1) ? $clog2(DISPLAY_BYTES) : 1;
	localparam int CW = $clog2(DISPLAY_BYTES + 1);
	localparam int LW = $clog2(LINE_LIMIT);
	localparam logic [LW-1:0] LINE_MAX = LW'(LINE_LIMIT - 1);
	localparam logic [CW-1:0] FULL     = CW'(DISPLAY_BYTES);
	localparam logic [AW-1:0] LAST_IDX = AW'(DISPLAY_BYTES - 1);

	hld_pkg::state_t state_q, state_d;

	logic [LW-1:0] line_count_q;
	logic          cmd_q;
	logic          stopped_q;
	logic          half_q;
	logic [3:0]    upper_q;
	logic [CW-1:0] written_q;
	logic [CW-1:0] emit_cnt_q;
	logic [AW-1:0] idx_q;
	logic [7:0]    mem [DISPLAY_BYTES];
	logic [7:0]    rd_data_q;

	logic          in_xfer;
	logic          out_xfer;
	logic          overrun;
	logic          is_lf;
	logic          start_emit;
	logic          full;
	hld_pkg::hex_t dig;
	logic          wr_en;

	assign in_xfer    = in_valid && !in_stall;
	assign out_xfer   = out_valid && !out_stall;
	assign overrun    = (line_count_q >= LINE_MAX);
	assign is_lf      = (rx_byte == hld_pkg::CHAR_LF);
	assign start_emit = in_xfer && !overrun && is_lf && cmd_q;
	assign full       = (written_q == FULL);
	assign dig        = hld_pkg::hex_decode(rx_byte);

	// A byte is stored when a low digit completes a pair on an active '@' line.
	assign wr_en = in_xfer && !overrun && !is_lf && line_count_q != '0 && cmd_q &&
		!stopped_q && !full && half_q && dig.ok;

	// Emit sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hld_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs.
	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			hld_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (start_emit) begin
					state_d = hld_pkg::ST_READ;
				end
			end
			hld_pkg::ST_READ: begin
				state_d = hld_pkg::ST_OUT;
			end
			hld_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = (idx_q == LAST_IDX) ? hld_pkg::ST_IDLE : hld_pkg::ST_READ;
				end
			end
			default: begin
				state_d = hld_pkg::ST_IDLE;
			end
		endcase
	end

	// Line and parse state; every line end or overrun clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= '0;
			cmd_q        <= 1'b0;
			stopped_q    <= 1'b0;
			half_q       <= 1'b0;
			upper_q      <= 4'h0;
			written_q    <= '0;
		end else if (in_xfer) begin
			if (overrun || is_lf) begin
				line_count_q <= '0;
				cmd_q        <= 1'b0;
				stopped_q    <= 1'b0;
				half_q       <= 1'b0;
				upper_q      <= 4'h0;
				written_q    <= '0;
			end else begin
				line_count_q <= line_count_q + LW'(1);
				if (line_count_q == '0) begin
					cmd_q <= (rx_byte == hld_pkg::CHAR_AT);
				end else if (cmd_q) begin
					if (stopped_q || full) begin
						stopped_q <= 1'b1;
					end else if (!half_q) begin
						// A NUL is not a digit, so it stops parsing here as well.
						if (!dig.ok) begin
							stopped_q <= 1'b1;
						end else begin
							upper_q <= dig.value;
							half_q  <= 1'b1;
						end
					end else begin
						half_q <= 1'b0;
						if (!dig.ok) begin
							stopped_q <= 1'b1;
						end else begin
							written_q <= written_q + CW'(1);
							if (written_q + CW'(1) == FULL) begin
								stopped_q <= 1'b1;
							end
						end
					end
				end
			end
		end
	end

	// Emit counters: the byte count is captured at the newline, the index walks
	// the image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_cnt_q <= '0;
			idx_q      <= '0;
		end else if (start_emit) begin
			emit_cnt_q <= written_q;
			idx_q      <= '0;
		end else if (out_xfer && idx_q != LAST_IDX) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	// Display memory. Writes happen only while idle and reads only during an
	// emit, so the two ports never touch the same entry in one cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[written_q[AW-1:0]] <= {upper_q, dig.value};
		end
		if (state_q == hld_pkg::ST_READ) begin
			rd_data_q <= mem[idx_q];
		end
	end

	// Output payload; entries beyond the byte count were not written this line.
	assign display_byte = (CW'(idx_q) < emit_cnt_q) ? rd_data_q : 8'h00;
	assign byte_index   = 6'(idx_q);
	assign last         = (idx_q == LAST_IDX);

endmodule
`default_nettype wire

/* src/hld_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hld_checker: port-level checks for the hex line display loader
// Watches the emit sequence and the channel interplay at the top level ports.
// ----------------------------------------------------------------------------
module hld_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] rx_byte,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] display_byte,
	input wire logic [5:0] byte_index,
	input wire logic       last
);

	// A stalled character holds until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(rx_byte))
		else $error("stalled character changed");

	// A stalled result holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(display_byte) &&
			$stable(byte_index) && $stable(last))
		else $error("stalled result changed");

	// No character is taken while an image is being shown.
	a_no_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open during emit");

	// After the final byte the block returns to taking characters.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> !out_valid && !in_stall)
		else $error("emit did not end after final byte");

	// A non-final transfer is followed by the next index after the memory read.
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> ##1 out_valid &&
			byte_index == $past(byte_index, 2) + 6'd1)
		else $error("image index did not advance");

endmodule

bind hex_line_display_loader hld_checker u_hld_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.rx_byte      (rx_byte),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.display_byte (display_byte),
	.byte_index   (byte_index),
	.last         (last)
);
`default_nettype wire
